[rtl/sus_pkg.sv]
`timescale 1ns / 1ps

package sus_pkg;

  // request kinds, carried on s_axis_tuser
  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_QUERY  = 2'd1,
    ACT_READ   = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_t;

  // result status codes
  typedef enum logic [1:0] {
    ST_DONE = 2'd0,
    ST_ZERO = 2'd1,
    ST_DUP  = 2'd2,
    ST_FULL = 2'd3
  } status_t;

  // controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_t;

  // fixed field widths of the stream payloads
  localparam int unsigned KeyFieldW  = 32;
  localparam int unsigned PosFieldW  = 3;
  localparam int unsigned CountFieldW = 4;
  localparam int unsigned InDataW    = 40;
  localparam int unsigned OutDataW   = 40;

  // controller to datapath
  typedef struct packed {
    logic load;   // capture the incoming request
    logic exec;   // run the request, update table and result register
  } sus_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic out_busy;  // result register holds a result not taken this cycle
  } sus_stat_t;

endpackage

[rtl/sorted_unique_key_set.sv]
`timescale 1ns / 1ps

// Sorted set of up to CAPACITY unique nonzero keys held in ascending order.
// Each request on s_axis is one of insert, query, read at index or clear
// (kind in s_axis_tuser) and yields exactly one result on m_axis with the
// status, the query hit flag, the read key and the key count after the
// request. Each request is first captured, and then all entries are
// compared against the key in parallel and the table is shifted for a
// sorted insert once the result register is free; the result register lets
// the next request come in while a result waits, but no new request is
// taken while one is executing. Keys wider than KEY_BITS are cut to their
// low KEY_BITS bits; key_count is reported modulo 16.
module sorted_unique_key_set #(
  parameter int unsigned CAPACITY = 8,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [sus_pkg::InDataW-1:0]    s_axis_tdata,   // key_value, position, zero pad
  input  logic [1:0]                     s_axis_tuser,   // action
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [sus_pkg::OutDataW-1:0]   m_axis_tdata    // status, found, read_value,
                                                         // key_count, zero pad
);
  import sus_pkg::*;

  sus_cmd_t                 cmd;
  sus_stat_t                stat;
  logic [1:0]               out_status;
  logic                     out_found;
  logic [KeyFieldW-1:0]     out_value;
  logic [CountFieldW-1:0]   out_count;

  // control
  sus_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .stat          (stat),
    .cmd           (cmd)
  );

  // table and result register
  sus_datapath #(
    .CAPACITY (CAPACITY),
    .KEY_BITS (KEY_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .in_action     (s_axis_tuser),
    .in_key        (s_axis_tdata[KeyFieldW-1:0]),
    .in_pos        (s_axis_tdata[KeyFieldW +: PosFieldW]),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .out_status    (out_status),
    .out_found     (out_found),
    .out_value     (out_value),
    .out_count     (out_count)
  );

  // pack the result
  assign m_axis_tdata = OutDataW'({out_count, out_value, out_found, out_status});

endmodule

[rtl/sus_ctrl.sv]
`timescale 1ns / 1ps

module sus_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_axis_tvalid,
  output logic               s_axis_tready,
  input  sus_pkg::sus_stat_t stat,
  output sus_pkg::sus_cmd_t  cmd
);
  import sus_pkg::*;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (s_axis_tvalid) state_next = S_EXEC;
      end
      S_EXEC: begin
        if (!stat.out_busy) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    s_axis_tready = 1'b0;
    cmd.load      = 1'b0;
    cmd.exec      = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_axis_tready = 1'b1;
        cmd.load      = s_axis_tvalid;
      end
      S_EXEC: begin
        cmd.exec = !stat.out_busy;
      end
      default: begin
        s_axis_tready = 1'b0;
      end
    endcase
  end

endmodule

[rtl/sus_datapath.sv]
`timescale 1ns / 1ps

module sus_datapath #(
  parameter int unsigned CAPACITY = 8,
  parameter int unsigned KEY_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst,
  input  sus_pkg::sus_cmd_t                 cmd,
  output sus_pkg::sus_stat_t                stat,
  input  logic [1:0]                        in_action,
  input  logic [sus_pkg::KeyFieldW-1:0]     in_key,
  input  logic [sus_pkg::PosFieldW-1:0]     in_pos,
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [1:0]                        out_status,
  output logic                              out_found,
  output logic [sus_pkg::KeyFieldW-1:0]     out_value,
  output logic [sus_pkg::CountFieldW-1:0]   out_count
);
  import sus_pkg::*;

  localparam int unsigned CW     = $clog2(CAPACITY + 1);
  localparam int unsigned IW     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CmpW   = (CW > PosFieldW) ? CW : PosFieldW;
  localparam int unsigned LowBits = (KEY_BITS < KeyFieldW) ? KEY_BITS : KeyFieldW;

  // captured request
  action_t               act_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [PosFieldW-1:0]  pos_r;

  // table
  logic [KEY_BITS-1:0]   keys [CAPACITY];
  logic [CW-1:0]         count;
  logic [CW-1:0]         count_next;

  // per-entry compares
  logic [CAPACITY-1:0]   eq;
  logic [CAPACITY-1:0]   gt;
  logic                  held;
  logic                  full;
  logic                  ins_ok;
  logic                  rd_ok;
  status_t               res_status;

  // request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      act_r <= action_t'(in_action);
      key_r <= KEY_BITS'(in_key[LowBits-1:0]);
      pos_r <= in_pos;
    end
  end

  // compare the key against every held entry
  always_comb begin
    for (int i = 0; i < CAPACITY; i++) begin
      eq[i] = (CW'(i) < count) && (keys[i] == key_r);
      gt[i] = (CW'(i) < count) && (keys[i] > key_r);
    end
  end

  assign held = |eq;
  assign full = (count == CW'(CAPACITY));
  assign rd_ok = (CmpW'(pos_r) < CmpW'(count));

  // insert decision
  always_comb begin
    res_status = ST_DONE;
    ins_ok     = 1'b0;
    if (act_r == ACT_INSERT) begin
      if (key_r == '0)      res_status = ST_ZERO;
      else if (held)        res_status = ST_DUP;
      else if (full)        res_status = ST_FULL;
      else                  ins_ok     = 1'b1;
    end
  end

  // count after the request
  always_comb begin
    count_next = count;
    if (act_r == ACT_CLEAR)  count_next = '0;
    else if (ins_ok)         count_next = count + CW'(1);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.exec) begin
      count <= count_next;
    end
  end

  // sorted insert: larger entries move up one slot, key lands in the gap
  for (genvar g = 0; g < CAPACITY; g++) begin : g_entry
    if (g == 0) begin : g_first
      always_ff @(posedge clk) begin
        if (cmd.exec && ins_ok && (gt[g] || (CW'(g) == count))) begin
          keys[g] <= key_r;
        end
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        if (cmd.exec && ins_ok) begin
          if (gt[g-1]) begin
            keys[g] <= keys[g-1];
          end else if (gt[g] || (CW'(g) == count)) begin
            keys[g] <= key_r;
          end
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (cmd.exec) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      out_status <= res_status;
      out_found  <= (act_r == ACT_QUERY) && (key_r != '0) && held;
      out_value  <= ((act_r == ACT_READ) && rd_ok) ?
                    KeyFieldW'(keys[IW'(pos_r)]) : '0;
      out_count  <= CountFieldW'(count_next);
    end
  end

  assign stat.out_busy = m_axis_tvalid && !m_axis_tready;

endmodule
